// ===== rtl/dht_pkg.sv =====
`timescale 1ns / 1ps

package dht_pkg;

   // Fixed field widths of the request and result items
   localparam int HASH_BITS    = 32;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int COUNT_BITS   = 9;
   localparam int CFG_BITS     = 9;

   // Defaults
   localparam int                  TABLE_DEPTH_DEFAULT = 256;
   localparam logic [CFG_BITS-1:0] MAX_ENTRIES_RESET   = 9'd128;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_ERASE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic [KEY_BITS-1:0]     key;
      logic [HASH_BITS-1:0]    key_hash;
      logic [PAYLOAD_BITS-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [PAYLOAD_BITS-1:0] found_value;
      logic [COUNT_BITS-1:0]   stored_count;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;         // latch the request
      logic home_go;      // start the home slot computation
      logic probe_init;   // probe from home, distance 0, carry the request
      logic mem_read;     // read the slot at the probe index
      logic advance;      // step to the next slot, distance + 1
      logic ins_swap;     // store carried entry, carry the richer resident
      logic wr_carried;   // store carried entry into an empty slot
      logic wr_payload;   // overwrite the payload of the matched slot
      logic erase_init;   // open the hole at the matched slot
      logic erase_shift;  // move the next resident back into the hole
      logic erase_stop;   // free the hole
      logic clear_step;   // clear one slot after reset
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic home_done;
      logic rd_valid;
      logic match;
      logic disp_lt_d;
      logic disp_zero;
      logic last_probe;
      logic erase_last;
      logic clear_last;
      logic full;
   } stat_type;

endpackage

// ===== rtl/dht_mod.sv =====
`timescale 1ns / 1ps

// Home slot unit: remainder of the hash by the table depth
module dht_mod #(
   parameter int TABLE_DEPTH = dht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [dht_pkg::HASH_BITS-1:0]      dividend,
   output logic                               done,
   output logic [$clog2(TABLE_DEPTH)-1:0]     remainder
);

   localparam int IDXW = $clog2(TABLE_DEPTH);
   localparam int HB   = dht_pkg::HASH_BITS;

   generate
      if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_pow2
         logic            done_ff;
         logic [IDXW-1:0] rem_ff;

         // Power of two depth: the low hash bits are the home slot
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               rem_ff <= dividend[IDXW-1:0];
            end
         end

         assign done      = done_ff;
         assign remainder = rem_ff;
      end else begin : g_recip
         localparam logic [HB-1:0] RECIP   = HB'((64'd1 << HB) / 64'(TABLE_DEPTH));
         localparam logic [HB-1:0] DEPTH_W = HB'(TABLE_DEPTH);

         logic            s1_ff;
         logic            s2_ff;
         logic            done_ff;
         logic [HB-1:0]   h_ff;
         logic [HB-1:0]   q_ff;
         logic [HB-1:0]   r_ff;
         logic [IDXW-1:0] rem_ff;
         logic [2*HB-1:0] prod;
         logic [HB-1:0]   qd;

         // Quotient estimate from a fixed reciprocal, at most one too low
         assign prod = (2*HB)'(dividend) * (2*HB)'(RECIP);
         assign qd   = q_ff * DEPTH_W;

         // Estimate, subtract, then one correcting subtract
         always_ff @(posedge clock) begin
            if (reset) begin
               s1_ff   <= 1'b0;
               s2_ff   <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               s1_ff   <= start;
               s2_ff   <= s1_ff;
               done_ff <= s2_ff;
            end
            if (start) begin
               h_ff <= dividend;
               q_ff <= prod[2*HB-1:HB];
            end
            if (s1_ff) begin
               r_ff <= h_ff - qd;
            end
            if (s2_ff) begin
               if (r_ff >= DEPTH_W) begin
                  rem_ff <= IDXW'(r_ff - DEPTH_W);
               end else begin
                  rem_ff <= IDXW'(r_ff);
               end
            end
         end

         assign done      = done_ff;
         assign remainder = rem_ff;
      end
   endgenerate

endmodule

// ===== rtl/dht_datapath.sv =====
`timescale 1ns / 1ps

module dht_datapath #(
   parameter int TABLE_DEPTH = dht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dht_pkg::req_type                    req_item,
   input  dht_pkg::cmd_type                    cmd,
   input  logic                                csr_write,
   input  logic [dht_pkg::CFG_BITS-1:0]        csr_data,
   output dht_pkg::stat_type                   stat,
   output logic [dht_pkg::PAYLOAD_BITS-1:0]    rd_payload,
   output logic [dht_pkg::COUNT_BITS-1:0]      stored_count
);

   localparam int IDXW = $clog2(TABLE_DEPTH);
   localparam int DW   = IDXW + 1;
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > dht_pkg::CFG_BITS) ? CW : dht_pkg::CFG_BITS;
   localparam int HB   = dht_pkg::HASH_BITS;
   localparam int KB   = dht_pkg::KEY_BITS;
   localparam int PB   = dht_pkg::PAYLOAD_BITS;

   // Slot store: one write or one read a cycle at one address
   logic          mem_valid [TABLE_DEPTH];
   logic [IDXW-1:0] mem_home [TABLE_DEPTH];
   logic [HB-1:0] mem_hash  [TABLE_DEPTH];
   logic [KB-1:0] mem_key   [TABLE_DEPTH];
   logic [PB-1:0] mem_pay   [TABLE_DEPTH];

   dht_pkg::req_type req_ff;
   logic [IDXW-1:0]  idx_ff;
   logic [IDXW-1:0]  hole_ff;
   logic [DW-1:0]    d_ff;
   logic [IDXW-1:0]  n_ff;
   logic [CW-1:0]    count_ff;
   logic [dht_pkg::CFG_BITS-1:0] max_ff;

   logic [IDXW-1:0]  car_home_ff;
   logic [HB-1:0]    car_hash_ff;
   logic [KB-1:0]    car_key_ff;
   logic [PB-1:0]    car_pay_ff;

   logic             rd_valid_ff;
   logic [IDXW-1:0]  rd_home_ff;
   logic [HB-1:0]    rd_hash_ff;
   logic [KB-1:0]    rd_key_ff;
   logic [PB-1:0]    rd_pay_ff;

   logic             home_done;
   logic [IDXW-1:0]  home_slot;
   logic [IDXW-1:0]  idx_next;
   logic [DW-1:0]    disp_raw;
   logic [DW-1:0]    disp;
   logic [CMPW-1:0]  count_ext;

   logic             we_valid;
   logic             we_entry;
   logic             we_pay;
   logic [IDXW-1:0]  wa;
   logic             wd_valid;
   logic [IDXW-1:0]  wd_home;
   logic [HB-1:0]    wd_hash;
   logic [KB-1:0]    wd_key;
   logic [PB-1:0]    wd_pay;

   dht_mod #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.home_go),
      .dividend  (req_ff.key_hash),
      .done      (home_done),
      .remainder (home_slot)
   );

   // Next slot with wrap-around
   assign idx_next = (idx_ff == IDXW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;

   // Displacement of the resident just read
   assign disp_raw = {1'b0, idx_ff} + DW'(TABLE_DEPTH) - {1'b0, rd_home_ff};
   assign disp     = (disp_raw >= DW'(TABLE_DEPTH)) ? disp_raw - DW'(TABLE_DEPTH) : disp_raw;

   assign count_ext = CMPW'(count_ff);

   always_comb begin
      stat.home_done  = home_done;
      stat.rd_valid   = rd_valid_ff;
      stat.match      = (rd_hash_ff == req_ff.key_hash) && (rd_key_ff == req_ff.key);
      stat.disp_lt_d  = disp < d_ff;
      stat.disp_zero  = disp == '0;
      stat.last_probe = d_ff == DW'(TABLE_DEPTH - 1);
      stat.erase_last = n_ff == IDXW'(TABLE_DEPTH - 1);
      stat.clear_last = idx_ff == IDXW'(TABLE_DEPTH - 1);
      stat.full       = (count_ext >= CMPW'(max_ff)) || (count_ext >= CMPW'(TABLE_DEPTH));
   end

   assign rd_payload   = rd_pay_ff;
   assign stored_count = count_ext[dht_pkg::COUNT_BITS-1:0];

   // Select what goes into the slot store
   always_comb begin
      we_valid = 1'b0;
      we_entry = 1'b0;
      we_pay   = 1'b0;
      wa       = idx_ff;
      wd_valid = 1'b0;
      wd_home  = car_home_ff;
      wd_hash  = car_hash_ff;
      wd_key   = car_key_ff;
      wd_pay   = car_pay_ff;
      if (cmd.wr_carried || cmd.ins_swap) begin
         we_valid = 1'b1;
         we_entry = 1'b1;
         we_pay   = 1'b1;
         wd_valid = 1'b1;
      end else if (cmd.wr_payload) begin
         we_pay = 1'b1;
         wd_pay = req_ff.new_value;
      end else if (cmd.erase_shift) begin
         we_valid = 1'b1;
         we_entry = 1'b1;
         we_pay   = 1'b1;
         wa       = hole_ff;
         wd_valid = 1'b1;
         wd_home  = rd_home_ff;
         wd_hash  = rd_hash_ff;
         wd_key   = rd_key_ff;
         wd_pay   = rd_pay_ff;
      end else if (cmd.erase_stop) begin
         we_valid = 1'b1;
         wa       = hole_ff;
      end else if (cmd.clear_step) begin
         we_valid = 1'b1;
      end
   end

   // Slot store write and registered read
   always_ff @(posedge clock) begin
      if (we_valid) begin
         mem_valid[wa] <= wd_valid;
      end
      if (we_entry) begin
         mem_home[wa] <= wd_home;
         mem_hash[wa] <= wd_hash;
         mem_key[wa]  <= wd_key;
      end
      if (we_pay) begin
         mem_pay[wa] <= wd_pay;
      end
      if (cmd.mem_read) begin
         rd_valid_ff <= mem_valid[idx_ff];
         rd_home_ff  <= mem_home[idx_ff];
         rd_hash_ff  <= mem_hash[idx_ff];
         rd_key_ff   <= mem_key[idx_ff];
         rd_pay_ff   <= mem_pay[idx_ff];
      end
   end

   // Probe pointers, carried entry and request
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.probe_init) begin
         idx_ff <= home_slot;
      end else if (cmd.advance || cmd.ins_swap || cmd.erase_init || cmd.erase_shift
                   || cmd.clear_step) begin
         idx_ff <= idx_next;
      end
      if (cmd.erase_init || cmd.erase_shift) begin
         hole_ff <= idx_ff;
      end
      if (cmd.erase_init) begin
         n_ff <= '0;
      end else if (cmd.erase_shift) begin
         n_ff <= n_ff + 1'b1;
      end
      if (cmd.probe_init) begin
         d_ff <= '0;
      end else if (cmd.advance) begin
         d_ff <= d_ff + 1'b1;
      end else if (cmd.ins_swap) begin
         d_ff <= disp + 1'b1;
      end
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.probe_init) begin
         car_home_ff <= home_slot;
         car_hash_ff <= req_ff.key_hash;
         car_key_ff  <= req_ff.key;
         car_pay_ff  <= req_ff.new_value;
      end else if (cmd.ins_swap) begin
         car_home_ff <= rd_home_ff;
         car_hash_ff <= rd_hash_ff;
         car_key_ff  <= rd_key_ff;
         car_pay_ff  <= rd_pay_ff;
      end
   end

   // Occupancy and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= dht_pkg::MAX_ENTRIES_RESET;
      end else begin
         if (cmd.wr_carried) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.erase_stop && (count_ff != '0)) begin
            count_ff <= count_ff - 1'b1;
         end
         if (csr_write) begin
            max_ff <= csr_data;
         end
      end
   end

endmodule

// ===== rtl/dht_ctrl.sv =====
`timescale 1ns / 1ps

module dht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_mode,
   input  dht_pkg::stat_type  stat,
   output dht_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_found
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME_GO,
      S_HOME_WAIT,
      S_LOC_RD,
      S_LOC_CHK,
      S_INS_RD,
      S_INS_CHK,
      S_ERS_RD,
      S_ERS_CHK
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       strobe_ff, strobe_in;
   logic [1:0] status_ff, status_in;
   logic       found_ff, found_in;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      found_in  = 1'b0;
      cmd       = '0;
      case (state_ff)
         // Sweep every slot to empty after reset
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
               case (req_mode)
                  dht_pkg::MODE_INSERT, dht_pkg::MODE_LOOKUP, dht_pkg::MODE_ERASE: begin
                     state_in = S_HOME_GO;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = dht_pkg::ST_NOT_FOUND;
                  end
               endcase
            end
         end
         S_HOME_GO: begin
            cmd.home_go = 1'b1;
            state_in    = S_HOME_WAIT;
         end
         S_HOME_WAIT: begin
            if (stat.home_done) begin
               cmd.probe_init = 1'b1;
               state_in       = S_LOC_RD;
            end
         end
         S_LOC_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_LOC_CHK;
         end
         // Search: stop at a match, an empty slot, a richer resident or the last probe
         S_LOC_CHK: begin
            if (stat.rd_valid && !stat.disp_lt_d && stat.match) begin
               case (mode_ff)
                  dht_pkg::MODE_INSERT: begin
                     cmd.wr_payload = 1'b1;
                     strobe_in      = 1'b1;
                     status_in      = dht_pkg::ST_DONE;
                     state_in       = S_IDLE;
                  end
                  dht_pkg::MODE_LOOKUP: begin
                     strobe_in = 1'b1;
                     found_in  = 1'b1;
                     status_in = dht_pkg::ST_DONE;
                     state_in  = S_IDLE;
                  end
                  dht_pkg::MODE_ERASE: begin
                     cmd.erase_init = 1'b1;
                     state_in       = S_ERS_RD;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = dht_pkg::ST_NOT_FOUND;
                     state_in  = S_IDLE;
                  end
               endcase
            end else if (!stat.rd_valid || stat.disp_lt_d || stat.last_probe) begin
               if ((mode_ff == dht_pkg::MODE_INSERT) && !stat.full) begin
                  cmd.probe_init = 1'b1;
                  state_in       = S_INS_RD;
               end else begin
                  strobe_in = 1'b1;
                  status_in = (mode_ff == dht_pkg::MODE_INSERT) ? dht_pkg::ST_FULL
                                                                : dht_pkg::ST_NOT_FOUND;
                  state_in  = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_LOC_RD;
            end
         end
         S_INS_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_INS_CHK;
         end
         // Insert walk: swap with richer residents until an empty slot
         S_INS_CHK: begin
            if (!stat.rd_valid) begin
               cmd.wr_carried = 1'b1;
               strobe_in      = 1'b1;
               status_in      = dht_pkg::ST_DONE;
               state_in       = S_IDLE;
            end else if (stat.disp_lt_d) begin
               cmd.ins_swap = 1'b1;
               state_in     = S_INS_RD;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_INS_RD;
            end
         end
         S_ERS_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_ERS_CHK;
         end
         // Backward shift until an empty slot, a resident at home or the last shift
         S_ERS_CHK: begin
            if (!stat.rd_valid || stat.disp_zero || stat.erase_last) begin
               cmd.erase_stop = 1'b1;
               strobe_in      = 1'b1;
               status_in      = dht_pkg::ST_DONE;
               state_in       = S_IDLE;
            end else begin
               cmd.erase_shift = 1'b1;
               state_in        = S_ERS_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         mode_ff   <= dht_pkg::MODE_LOOKUP;
         strobe_ff <= 1'b0;
         status_ff <= dht_pkg::ST_DONE;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         strobe_ff <= strobe_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;

endmodule

// ===== rtl/displacement_hash_table.sv =====
`timescale 1ns / 1ps

// Robin Hood hash table with linear probing and backward-shift erase.
// Request channel: drive req_item (mode, key, key_hash, new_value) with start;
// the request is taken on a clock edge where start is high and busy is low.
// Result channel: one result per request, shown on rsp_item for exactly one
// cycle while rsp_strobe is high; the receiver cannot stall it.
// Limit register: csr_data is written to max_entries when csr_valid is high;
// csr_ready is always high. Write it only while the table is idle.
// Sequence: the request is latched, then the home slot unit is started; with a
// depth that is not a power of two its result passes the estimate, subtract and
// correction registers. Each slot probed by the search, walked by an insert or
// moved back by an erase takes a read state and a check state, as the slot store
// has a single port; the result strobe is registered. One request is in work
// at a time. Unused mode 3 answers "not found" in the cycle after it is taken.
// Reset: busy stays high while every slot is cleared;
// the count goes to 0 and max_entries to 128.
module displacement_hash_table #(
   parameter int TABLE_DEPTH = dht_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  dht_pkg::req_type               req_item,
   output logic                           rsp_strobe,
   output dht_pkg::rsp_type               rsp_item,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dht_pkg::CFG_BITS-1:0]   csr_data
);

   dht_pkg::cmd_type  cmd;
   dht_pkg::stat_type stat;
   logic [1:0]                        rsp_status;
   logic                              rsp_found;
   logic [dht_pkg::PAYLOAD_BITS-1:0]  rd_payload;
   logic [dht_pkg::COUNT_BITS-1:0]    stored_count;

   assign csr_ready = 1'b1;

   dht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_mode   (req_item.mode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found)
   );

   dht_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .cmd          (cmd),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .stat         (stat),
      .rd_payload   (rd_payload),
      .stored_count (stored_count)
   );

   // Assemble the result
   always_comb begin
      rsp_item.status       = rsp_status;
      rsp_item.found_value  = rsp_found ? rd_payload : '0;
      rsp_item.stored_count = stored_count;
   end

   // A result only appears once the controller has gone back to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // A real operation always occupies the controller
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.mode == dht_pkg::MODE_INSERT
                          || req_item.mode == dht_pkg::MODE_LOOKUP
                          || req_item.mode == dht_pkg::MODE_ERASE)) |=> busy)
      else $error("request taken without entering work");

   // Only a successful lookup returns a payload
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.status != dht_pkg::ST_DONE)) |-> (rsp_item.found_value == '0))
      else $error("payload returned on a failed request");

endmodule
